// ===== rtl/tdde_pkg.sv =====
// Shared types, constants and helpers for the table-driven DFA engine.
package tdde_pkg;

    localparam int MAX_STATES    = 64;
    localparam int ALPHABET_SIZE = 128;

    localparam int OP_W    = 3;
    localparam int SYM_W   = 7;
    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int ALPHA_W = $clog2(ALPHABET_SIZE);
    localparam int PROP_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 7;
    localparam int TADDR_W = STATE_W + ALPHA_W;
    localparam int TDEPTH  = MAX_STATES * ALPHABET_SIZE;

    localparam logic [ALPHA_W-1:0] ALPHA_LAST = ALPHA_W'(ALPHABET_SIZE - 1);
    localparam logic [CFG_W-1:0]   CFG_MAX    = CFG_W'(MAX_STATES);

    typedef enum logic [OP_W-1:0] {
        OP_STEP      = 3'd0,
        OP_PEEK      = 3'd1,
        OP_SET_TRANS = 3'd2,
        OP_CLR_TRANS = 3'd3,
        OP_SET_ATTR  = 3'd4,
        OP_RESTART   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOTRANS    = 2'd1,
        ST_NOTSTARTED = 2'd2,
        ST_BAD        = 2'd3
    } status_t;

    localparam logic [PROP_W-1:0] PROP_NONE  = 2'd0;
    localparam logic [PROP_W-1:0] PROP_TRAP  = 2'd1;
    localparam logic [PROP_W-1:0] PROP_ERROR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_EXEC,
        S_SETTLE,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] state_index;
        logic [STATE_W-1:0] target_state;
        logic               final_flag;
        logic [PROP_W-1:0]  property_req;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] cur_state;
        logic [STATE_W-1:0] nxt_state;
        logic               next_valid;
        logic               accepting;
        logic [PROP_W-1:0]  state_property;
        logic [STAT_W-1:0]  status;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } trans_entry_t;

    typedef struct packed {
        logic              final_flag;
        logic [PROP_W-1:0] prop;
    } attr_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic sweep_wr;
        logic row_mark;
        logic exec;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_sweep;
        logic sweep_last;
    } dp_stat_t;

    typedef struct packed {
        logic             en;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
    } cfg_clr_t;

    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        return (v > CFG_MAX) ? CFG_MAX : v;
    endfunction

endpackage

// ===== rtl/tdde_ctrl.sv =====
// Sequencing state machine for the DFA engine: accept, decode, sweep, execute, settle, deliver.
module tdde_ctrl import tdde_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     out_free,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     out_load
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                // a fresh row gets wiped before its first entry lands
                state_next = stat.needs_sweep ? S_SWEEP : S_EXEC;
            end
            S_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    cmd.row_mark = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_SETTLE;
            end
            S_SETTLE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tdde_dp.sv =====
// Datapath of the DFA engine: item register, transition and attribute memories, state.
module tdde_dp import tdde_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  item_t            s_item,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  cfg_clr_t         cfg_clr,
    input  logic [CFG_W-1:0] live_n,
    output result_t          result
);

    item_t                   item_reg;
    logic [STATE_W-1:0]      cur_reg, cur_next;
    logic                    started_reg, started_next;
    logic [MAX_STATES-1:0]   row_live_reg, row_live_next;
    logic [MAX_STATES-1:0]   attr_valid_reg, attr_valid_next;
    logic [MAX_STATES-1:0]   grow_mask;
    logic [ALPHA_W-1:0]      sweep_cnt_reg;

    trans_entry_t            trans_mem [TDEPTH];
    trans_entry_t            trans_rd_reg;
    attr_t                   attr_mem [MAX_STATES];
    attr_t                   attr_rd_reg;

    logic [STATE_W-1:0]      res_next_reg, res_next_next;
    logic                    res_nvalid_reg, res_nvalid_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;

    logic                    sym_ok, sidx_ok, tgt_ok, cur_ok, hit;
    logic                    edit_we, attr_we;
    trans_entry_t            edit_data;
    logic                    tm_we;
    logic [TADDR_W-1:0]      tm_waddr, tm_raddr;
    trans_entry_t            tm_wdata;

    assign sym_ok  = {1'b0, item_reg.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
    assign sidx_ok = CFG_W'(item_reg.state_index) < live_n;
    assign tgt_ok  = CFG_W'(item_reg.target_state) < live_n;
    assign cur_ok  = started_reg && (CFG_W'(cur_reg) < live_n);
    assign hit     = sym_ok && row_live_reg[cur_reg] && trans_rd_reg.valid;

    assign stat.needs_sweep = (item_reg.op == OP_SET_TRANS) && sidx_ok && tgt_ok && sym_ok
                              && !row_live_reg[item_reg.state_index];
    assign stat.sweep_last  = sweep_cnt_reg == ALPHA_LAST;

    // execute: next state, flags and store writes for the held item
    always_comb begin
        cur_next        = cur_reg;
        started_next    = started_reg;
        res_next_next   = '0;
        res_nvalid_next = 1'b0;
        res_status_next = ST_OK;
        edit_we         = 1'b0;
        edit_data       = '0;
        attr_we         = 1'b0;
        case (item_reg.op)
            OP_STEP, OP_PEEK: begin
                if (!started_reg) begin
                    res_status_next = ST_NOTSTARTED;
                end else if (!cur_ok) begin
                    res_status_next = ST_BAD;
                end else begin
                    res_nvalid_next = hit;
                    res_next_next   = hit ? trans_rd_reg.next : '0;
                    if (item_reg.op == OP_STEP) begin
                        cur_next        = hit ? trans_rd_reg.next : '0;
                        res_status_next = hit ? ST_OK : ST_NOTRANS;
                    end
                end
            end
            OP_SET_TRANS: begin
                if (sidx_ok && tgt_ok && sym_ok) begin
                    edit_we        = 1'b1;
                    edit_data.valid = 1'b1;
                    edit_data.next  = item_reg.target_state;
                end else begin
                    res_status_next = ST_BAD;
                end
            end
            OP_CLR_TRANS: begin
                if (sidx_ok && sym_ok) begin
                    edit_we = 1'b1;
                end else begin
                    res_status_next = ST_BAD;
                end
            end
            OP_SET_ATTR: begin
                if (sidx_ok && item_reg.property_req <= PROP_ERROR) begin
                    attr_we = 1'b1;
                end else begin
                    res_status_next = ST_BAD;
                end
            end
            OP_RESTART: begin
                cur_next     = '0;
                started_next = 1'b1;
            end
            default: begin
                res_status_next = ST_BAD;
            end
        endcase
    end

    always_comb begin
        for (int s = 0; s < MAX_STATES; s++) begin
            grow_mask[s] = cfg_clr.en && (CFG_W'(s) >= cfg_clr.lo) && (CFG_W'(s) < cfg_clr.hi);
        end
    end

    always_comb begin
        row_live_next   = row_live_reg & ~grow_mask;
        attr_valid_next = attr_valid_reg & ~grow_mask;
        if (cmd.row_mark) begin
            row_live_next[item_reg.state_index] = 1'b1;
        end
        if (cmd.exec && attr_we) begin
            attr_valid_next[item_reg.state_index] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= '0;
            started_reg    <= 1'b0;
            row_live_reg   <= '0;
            attr_valid_reg <= '0;
            sweep_cnt_reg  <= '0;
        end else begin
            row_live_reg   <= row_live_next;
            attr_valid_reg <= attr_valid_next;
            if (cmd.load) begin
                sweep_cnt_reg <= '0;
            end else if (cmd.sweep_wr) begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.exec) begin
                cur_reg     <= cur_next;
                started_reg <= started_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.exec) begin
            res_next_reg   <= res_next_next;
            res_nvalid_reg <= res_nvalid_next;
            res_status_reg <= res_status_next;
        end
    end

    assign tm_we    = cmd.sweep_wr || (cmd.exec && edit_we);
    assign tm_waddr = cmd.sweep_wr ? {item_reg.state_index, sweep_cnt_reg}
                                   : {item_reg.state_index, item_reg.symbol[ALPHA_W-1:0]};
    assign tm_wdata = cmd.sweep_wr ? trans_entry_t'('0) : edit_data;
    assign tm_raddr = {cur_reg, item_reg.symbol[ALPHA_W-1:0]};

    always_ff @(posedge aclk) begin
        if (tm_we) begin
            trans_mem[tm_waddr] <= tm_wdata;
        end
        trans_rd_reg <= trans_mem[tm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && attr_we) begin
            attr_mem[item_reg.state_index] <= {item_reg.final_flag, item_reg.property_req};
        end
        attr_rd_reg <= attr_mem[cur_reg];
    end

    always_comb begin
        result.cur_state      = cur_reg;
        result.nxt_state      = res_next_reg;
        result.next_valid     = res_nvalid_reg;
        result.accepting      = 1'b0;
        result.state_property = PROP_NONE;
        result.status         = res_status_reg;
        if (cur_ok && attr_valid_reg[cur_reg]) begin
            result.accepting      = attr_rd_reg.final_flag;
            result.state_property = attr_rd_reg.prop;
        end
    end

endmodule

// ===== rtl/table_driven_dfa_engine_core.sv =====
// Table-driven DFA engine over 7-bit symbols: one command item in, one result item out.
// Each item passes through these steps from acceptance to a result in the output register:
// capture, a registered read of the transition memory at the current state and symbol,
// execute, a registered read of the attribute memory at the new current state, deliver.
// A set-transition on a state row not written since reset, or since the state count last
// grew over it, first wipes that row of the transition memory, one entry a cycle; no
// clearing pass follows reset. The result waits in an output register, and the next
// item is taken once the engine is back to idle. state_count is written through cfg_we and
// cfg_wdata; write it only while no item is in flight: the block does not enforce this.
module table_driven_dfa_engine_core import tdde_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,    // state_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,      // symbol, state_index, target_state,
                                           // final_flag, property_req, zero pad
    input  logic [OP_W-1:0]  s_tuser,      // op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata       // cur_state, nxt_state, next_valid,
                                           // accepting, state_property, status, zero pad
);

    logic [CFG_W-1:0] state_count_reg;
    logic [CFG_W-1:0] live_n;
    cfg_clr_t         cfg_clr;
    item_t            s_item;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    result_t          result;
    result_t          m_res_reg;
    logic             m_tvalid_reg;
    logic             out_free, out_load;

    assign live_n = clamp_count(state_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg <= '0;
        end else if (cfg_we) begin
            state_count_reg <= cfg_wdata;
        end
    end

    // states added by a larger count come back empty
    assign cfg_clr.en = cfg_we;
    assign cfg_clr.lo = live_n;
    assign cfg_clr.hi = clamp_count(cfg_wdata);

    assign s_item.op           = s_tuser;
    assign s_item.symbol       = s_tdata[6:0];
    assign s_item.state_index  = s_tdata[12:7];
    assign s_item.target_state = s_tdata[18:13];
    assign s_item.final_flag   = s_tdata[19];
    assign s_item.property_req = s_tdata[21:20];

    tdde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .out_load (out_load)
    );

    tdde_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .cfg_clr (cfg_clr),
        .live_n  (live_n),
        .result  (result)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.status, m_res_reg.state_property, m_res_reg.accepting,
                       m_res_reg.next_valid, m_res_reg.nxt_state, m_res_reg.cur_state};

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("engine stayed ready after taking an item");

    a_notrans_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_res_reg.status == ST_NOTRANS) |->
            (m_res_reg.cur_state == '0 && !m_res_reg.next_valid))
        else $error("missing transition did not fall back to state 0");

    a_notstarted_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_res_reg.status == ST_NOTSTARTED) |->
            (m_res_reg.cur_state == '0 && !m_res_reg.accepting &&
             m_res_reg.state_property == PROP_NONE))
        else $error("not-started result carries state or attributes");

    a_next_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_res_reg.next_valid) |-> (m_res_reg.nxt_state == '0))
        else $error("next state nonzero without a transition");

endmodule
